### design/js3d_pkg.sv
// Package for the 3D Jacobi stencil step: defaults, register map, constants.
// Used by jacobi_stencil_3d_step_top and by js3d_checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package js3d_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int MAX_X_DEF     = 64;
    localparam int MAX_Y_DEF     = 64;
    localparam int FRAC_BITS_DEF = 16;

    // Plane count limit and the width of the plane counter.
    localparam int MAX_Z = 1024;
    localparam int ZW    = 10;

    // Smallest legal grid size along any axis.
    localparam int SIZE_MIN = 3;

    // Register widths.
    localparam int SXY_W = 7;
    localparam int SZ_W  = 11;

    // Configuration port.
    localparam int PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2,
        REG_GAIN   = 2'd3
    } reg_idx_t;

    localparam logic [SXY_W-1:0] SIZE_X_RST = 7'd64;
    localparam logic [SXY_W-1:0] SIZE_Y_RST = 7'd64;
    localparam logic [SZ_W-1:0]  SIZE_Z_RST = 11'd64;
    localparam logic [31:0]      GAIN_RST   = 32'd65536;

    // floor(2^34 / 3): reciprocal for the divide-by-three step.
    localparam logic [32:0] DIV3_MUL = 33'd5726623061;

    // Depth of the result queue, in input beats.
    localparam int OUT_DEPTH = 8;

endpackage : js3d_pkg

`default_nettype wire

### design/jacobi_stencil_3d_step_top.sv
// Top level of the 3D Jacobi 7-point stencil step with plane memories and
// result queue. Depends on js3d_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake         Payload
// s_        in   s_tvalid/tready   s_tdata: old_value[31:0], source_value[63:32]
// m_        out  m_tvalid/tready   m_tdata: new_value; m_tuser: is_boundary, grid_end;
//                                  m_tlast: last
// APB       in   psel/penable      size_x @0, size_y @4, size_z @8, source_gain @12
//
// One input beat is taken per clock while s_tready is high. A beat of plane 0
// yields no result, a beat of the last plane yields two results, any other beat
// yields one; the output side moves one result per clock while m_tready is high,
// so on the last plane the output side, not the input, sets the pace. Results leave
// through the multiply and divide-by-six pipeline behind the plane memory read.
// Reset (aresetn, synchronous, active low) clears the counters, the pipeline valid
// bits and the result queue; the memories hold no reset value. s_tready drops only
// when the result queue plus the beats in flight would fill the queue.

module jacobi_stencil_3d_step_top #(
    parameter int MAX_X     = js3d_pkg::MAX_X_DEF,
    parameter int MAX_Y     = js3d_pkg::MAX_Y_DEF,
    parameter int FRAC_BITS = js3d_pkg::FRAC_BITS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    // s_tdata: old_value [31:0], source_value [63:32]
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [63:0]                  s_tdata,
    // m_tdata: new_value [31:0]
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [31:0]                  m_tdata,
    // m_tuser: is_boundary [0], grid_end [1]
    output logic [1:0]                   m_tuser,
    output logic                         m_tlast,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [js3d_pkg::PADDR_W-1:0] paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int XW     = $clog2(MAX_X);
    localparam int YW     = $clog2(MAX_Y);
    localparam int YD     = (MAX_Y + 2) / 3;
    localparam int YDW    = (YD > 1) ? $clog2(YD) : 1;
    localparam int BW     = YDW + XW;
    localparam int BDEPTH = YD * (2 ** XW);
    localparam int SAW    = YW + XW;
    localparam int SDEPTH = MAX_Y * (2 ** XW);
    localparam int ZW     = js3d_pkg::ZW;
    localparam int QD     = js3d_pkg::OUT_DEPTH;
    localparam int QW     = $clog2(QD);
    localparam int QCW    = $clog2(QD + 1);
    localparam int TW     = QCW + 1;
    localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

    typedef struct packed {
        logic        has0;
        logic        bnd0;
        logic        last0;
        logic        has1;
        logic        end1;
        logic [31:0] val1;
        logic [31:0] centre;
    } meta_t;

    typedef struct packed {
        logic        has0;
        logic        bnd0;
        logic        last0;
        logic        has1;
        logic        end1;
        logic [31:0] val0;
        logic [31:0] val1;
    } entry_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [js3d_pkg::SXY_W-1:0] size_x_reg, size_y_reg;
    logic [js3d_pkg::SZ_W-1:0]  size_z_reg;
    logic [31:0]                gain_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= js3d_pkg::SIZE_X_RST;
            size_y_reg <= js3d_pkg::SIZE_Y_RST;
            size_z_reg <= js3d_pkg::SIZE_Z_RST;
            gain_reg   <= js3d_pkg::GAIN_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                js3d_pkg::REG_SIZE_X: size_x_reg <= pwdata[js3d_pkg::SXY_W-1:0];
                js3d_pkg::REG_SIZE_Y: size_y_reg <= pwdata[js3d_pkg::SXY_W-1:0];
                js3d_pkg::REG_SIZE_Z: size_z_reg <= pwdata[js3d_pkg::SZ_W-1:0];
                js3d_pkg::REG_GAIN:   gain_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            js3d_pkg::REG_SIZE_X: prdata = 32'(size_x_reg);
            js3d_pkg::REG_SIZE_Y: prdata = 32'(size_y_reg);
            js3d_pkg::REG_SIZE_Z: prdata = 32'(size_z_reg);
            js3d_pkg::REG_GAIN:   prdata = gain_reg;
            default:              prdata = 32'd0;
        endcase
    end

    // Sizes are clamped into their legal range when used; the "minus one"
    // forms are what the counters compare against.
    logic [31:0] sx_m1, sy_m1, sz_m1;

    always_comb begin
        if (32'(size_x_reg) < 32'(js3d_pkg::SIZE_MIN))  sx_m1 = 32'(js3d_pkg::SIZE_MIN - 1);
        else if (32'(size_x_reg) > 32'(MAX_X))           sx_m1 = 32'(MAX_X - 1);
        else                                             sx_m1 = 32'(size_x_reg) - 32'd1;
        if (32'(size_y_reg) < 32'(js3d_pkg::SIZE_MIN))  sy_m1 = 32'(js3d_pkg::SIZE_MIN - 1);
        else if (32'(size_y_reg) > 32'(MAX_Y))           sy_m1 = 32'(MAX_Y - 1);
        else                                             sy_m1 = 32'(size_y_reg) - 32'd1;
        if (32'(size_z_reg) < 32'(js3d_pkg::SIZE_MIN))  sz_m1 = 32'(js3d_pkg::SIZE_MIN - 1);
        else if (32'(size_z_reg) > 32'(js3d_pkg::MAX_Z)) sz_m1 = 32'(js3d_pkg::MAX_Z - 1);
        else                                             sz_m1 = 32'(size_z_reg) - 32'd1;
    end

    // ------------------------------------------------------------------
    // Position counters. Rows are also tracked as row/3 and row%3 because
    // the value planes are banked by row modulo three, so that the rows
    // above, at and below a point sit in three different memories.
    // ------------------------------------------------------------------
    logic [XW-1:0]  x_reg;
    logic [YW-1:0]  y_reg;
    logic [YDW-1:0] ydiv_reg;
    logic [1:0]     ymod_reg;
    logic [ZW-1:0]  z_reg;
    logic           s_accept;
    logic           x_last, y_last, z_last;

    assign s_accept = s_tvalid && s_tready;
    assign x_last   = 32'(x_reg) >= sx_m1;
    assign y_last   = 32'(y_reg) >= sy_m1;
    assign z_last   = 32'(z_reg) >= sz_m1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg    <= '0;
            y_reg    <= '0;
            ydiv_reg <= '0;
            ymod_reg <= '0;
            z_reg    <= '0;
        end else if (s_accept) begin
            if (x_last) begin
                x_reg <= '0;
                if (y_last) begin
                    y_reg    <= '0;
                    ydiv_reg <= '0;
                    ymod_reg <= '0;
                    z_reg    <= z_last ? '0 : z_reg + 1'b1;
                end else begin
                    y_reg <= y_reg + 1'b1;
                    if (ymod_reg == 2'd2) begin
                        ymod_reg <= 2'd0;
                        ydiv_reg <= ydiv_reg + 1'b1;
                    end else begin
                        ymod_reg <= ymod_reg + 2'd1;
                    end
                end
            end else begin
                x_reg <= x_reg + 1'b1;
            end
        end
    end

    // Neighbour banks and their row addresses.
    logic [1:0]     bank_up, bank_dn;
    logic [YDW-1:0] ydiv_up, ydiv_dn;

    always_comb begin
        bank_up = (ymod_reg == 2'd0) ? 2'd2 : ymod_reg - 2'd1;
        bank_dn = (ymod_reg == 2'd2) ? 2'd0 : ymod_reg + 2'd1;
        ydiv_up = (ymod_reg == 2'd0) ? ydiv_reg - 1'b1 : ydiv_reg;
        ydiv_dn = (ymod_reg == 2'd2) ? ydiv_reg + 1'b1 : ydiv_reg;
    end

    // ------------------------------------------------------------------
    // Value plane memories: two halves (plane parity) by three row banks.
    // Port 0 reads the point itself (or the row above/below in the
    // neighbour banks); port 1 reads the point to the right. The half of
    // the current plane is read before it is overwritten in the same
    // edge, which yields the value two planes back.
    // ------------------------------------------------------------------
    logic [31:0]   rd0_w [2][3];
    logic [31:0]   rd1_w [2][3];
    logic [BW-1:0] addr_cur, addr_right;

    assign addr_cur   = {ydiv_reg, x_reg};
    assign addr_right = {ydiv_reg, x_reg + 1'b1};

    for (genvar h = 0; h < 2; h++) begin : g_half
        for (genvar b = 0; b < 3; b++) begin : g_bank
            logic [31:0]   mem [BDEPTH];
            logic [31:0]   rd0_reg, rd1_reg;
            logic [BW-1:0] addr0;
            logic          we;

            always_comb begin
                if (bank_up == 2'(b))      addr0 = {ydiv_up, x_reg};
                else if (bank_dn == 2'(b)) addr0 = {ydiv_dn, x_reg};
                else                       addr0 = addr_cur;
            end

            assign we = s_accept && (z_reg[0] == 1'(h)) && (ymod_reg == 2'(b));

            always_ff @(posedge aclk) begin
                if (s_accept) begin
                    rd0_reg <= mem[addr0];
                    rd1_reg <= mem[addr_right];
                end
                if (we) begin
                    mem[addr_cur] <= s_tdata[31:0];
                end
            end

            assign rd0_w[h][b] = rd0_reg;
            assign rd1_w[h][b] = rd1_reg;
        end
    end

    // Source plane memory, read before write at the same point.
    logic [31:0]    smem [SDEPTH];
    logic [31:0]    src_rd_reg;
    logic [SAW-1:0] saddr;

    assign saddr = {y_reg, x_reg};

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            src_rd_reg  <= smem[saddr];
            smem[saddr] <= s_tdata[63:32];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: read data is valid. The left neighbour is the centre read
    // of the previous beat, which for an interior point was the point
    // just before it in the same row.
    // ------------------------------------------------------------------
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    meta_t       m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    logic        p1_prv_reg;
    logic [1:0]  p1_bank_reg, p1_up_reg, p1_dn_reg;
    logic [31:0] left_reg;
    logic [31:0] centre_now;
    meta_t       m_in;

    assign centre_now = rd0_w[p1_prv_reg][p1_bank_reg];

    always_comb begin
        m_in        = '0;
        m_in.has0   = z_reg != '0;
        m_in.bnd0   = (z_reg == ZW'(1)) || (32'(z_reg) > sz_m1) || (x_reg == '0)
                      || (y_reg == '0) || x_last || y_last;
        m_in.last0  = !z_last;
        m_in.has1   = z_last;
        m_in.end1   = x_last && y_last;
        m_in.val1   = s_tdata[31:0];
        m_in.centre = '0;
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m1_reg      <= m_in;
            p1_prv_reg  <= ~z_reg[0];
            p1_bank_reg <= ymod_reg;
            p1_up_reg   <= bank_up;
            p1_dn_reg   <= bank_dn;
            left_reg    <= centre_now;
        end
    end

    logic signed [34:0] sum6;

    always_comb begin
        sum6 = 35'(signed'(m1_reg.val1))
             + 35'(signed'(rd0_w[~p1_prv_reg][p1_bank_reg]))
             + 35'(signed'(left_reg))
             + 35'(signed'(rd1_w[p1_prv_reg][p1_bank_reg]))
             + 35'(signed'(rd0_w[p1_prv_reg][p1_up_reg]))
             + 35'(signed'(rd0_w[p1_prv_reg][p1_dn_reg]));
    end

    // The centre value joins the beat's side data on its way to stage 2.
    meta_t m1_cen;

    always_comb begin
        m1_cen        = m1_reg;
        m1_cen.centre = centre_now;
    end

    // Stage 2: six-point sum and source product.
    logic signed [34:0] p2_sum_reg;
    logic signed [63:0] p2_prod_reg;
    logic signed [35:0] n_biased;

    always_ff @(posedge aclk) begin
        p2_sum_reg  <= sum6;
        p2_prod_reg <= signed'(gain_reg) * signed'(src_rd_reg);
        m2_reg      <= m1_cen;
    end

    // Stage 3: round(sum/6) = floor((sum + 3 + 6*2^31) / 6) - 2^31, done as
    // floor(h/3) with h the biased value halved; h/3 by reciprocal in two
    // partial products.
    assign n_biased = 36'(p2_sum_reg) + 36'sd3 + 36'sd12884901888;

    logic [33:0]        p3_h_reg;
    logic [49:0]        p3_phi_reg, p3_plo_reg;
    logic signed [63:0] p3_t2_reg;

    always_ff @(posedge aclk) begin
        p3_h_reg   <= n_biased[34:1];
        p3_phi_reg <= 50'(n_biased[34:18]) * 50'(js3d_pkg::DIV3_MUL);
        p3_plo_reg <= 50'(n_biased[17:1]) * 50'(js3d_pkg::DIV3_MUL);
        p3_t2_reg  <= (p2_prod_reg + RND) >>> FRAC_BITS;
        m3_reg     <= m2_reg;
    end

    // Stage 4: quotient estimate, at most one short.
    logic [66:0]        qprod;
    logic [33:0]        p4_h_reg;
    logic [32:0]        p4_q0_reg;
    logic signed [63:0] p4_t2_reg;

    assign qprod = {p3_phi_reg, 17'b0} + 67'(p3_plo_reg);

    always_ff @(posedge aclk) begin
        p4_h_reg  <= p3_h_reg;
        p4_q0_reg <= qprod[66:34];
        p4_t2_reg <= p3_t2_reg;
        m4_reg    <= m3_reg;
    end

    // Stage 5: correct the quotient and remove the bias.
    logic [34:0]        rem3;
    logic [32:0]        q_fix;
    logic signed [33:0] p5_t1_reg;
    logic signed [63:0] p5_t2_reg;

    always_comb begin
        rem3  = 35'(p4_h_reg) - (35'({p4_q0_reg, 1'b0}) + 35'(p4_q0_reg));
        q_fix = p4_q0_reg + 33'(rem3 >= 35'd3);
    end

    always_ff @(posedge aclk) begin
        p5_t1_reg <= signed'({1'b0, q_fix}) - 34'sd2147483648;
        p5_t2_reg <= p4_t2_reg;
        m5_reg    <= m4_reg;
    end

    // Final add with saturation, then into the result queue.
    logic signed [64:0] res_full;
    logic [31:0]        res_sat;
    entry_t             q_in;

    always_comb begin
        res_full = 65'(p5_t1_reg) + 65'(p5_t2_reg);
        if (res_full > 65'sd2147483647)       res_sat = 32'h7FFF_FFFF;
        else if (res_full < -65'sd2147483648) res_sat = 32'h8000_0000;
        else                                  res_sat = res_full[31:0];
        q_in.has0  = m5_reg.has0;
        q_in.bnd0  = m5_reg.bnd0;
        q_in.last0 = m5_reg.last0;
        q_in.has1  = m5_reg.has1;
        q_in.end1  = m5_reg.end1;
        q_in.val0  = m5_reg.bnd0 ? m5_reg.centre : res_sat;
        q_in.val1  = m5_reg.val1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v1_reg <= s_accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result queue. Every beat in flight holds a reserved slot, so the
    // pipeline never stalls and s_tready depends only on registers.
    // ------------------------------------------------------------------
    entry_t         q_mem [QD];
    logic [QW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0] count_reg;
    logic           phase_reg;
    logic           push, pop, sel0, final_beat, m_accept;
    logic [TW-1:0]  occupancy;
    entry_t         head;

    assign occupancy = TW'(count_reg) + TW'(v1_reg) + TW'(v2_reg) + TW'(v3_reg)
                     + TW'(v4_reg) + TW'(v5_reg);
    assign s_tready  = occupancy < TW'(QD);

    assign push       = v5_reg && (m5_reg.has0 || m5_reg.has1);
    assign head       = q_mem[rd_ptr_reg];
    assign m_tvalid   = count_reg != '0;
    assign sel0       = head.has0 && !phase_reg;
    assign final_beat = !sel0 || !head.has1;
    assign m_accept   = m_tvalid && m_tready;
    assign pop        = m_accept && final_beat;

    assign m_tdata = sel0 ? head.val0 : head.val1;
    assign m_tuser = sel0 ? {1'b0, head.bnd0} : {head.end1, 1'b1};
    assign m_tlast = sel0 ? head.last0 : 1'b1;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= q_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            phase_reg  <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (m_accept) begin
                phase_reg <= !final_beat;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCW'(push) - QCW'(pop);
        end
    end

endmodule : jacobi_stencil_3d_step_top

`default_nettype wire

### design/js3d_checker.sv
// Port-level checks for jacobi_stencil_3d_step_top, bound to it below.
// Depends on js3d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module js3d_port_assert (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [31:0]                   m_tdata,
    input wire [1:0]                    m_tuser,
    input wire                          m_tlast,
    input wire                          psel,
    input wire                          penable,
    input wire                          pwrite,
    input wire [js3d_pkg::PADDR_W-1:0]  paddr,
    input wire [31:0]                   pwdata,
    input wire [31:0]                   prdata,
    input wire                          pready
);

    localparam logic [js3d_pkg::PADDR_W-1:0] GAIN_ADDR = {js3d_pkg::REG_GAIN, 2'b00};

    // The result queue is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // The end-of-grid mark only sits on the pass-through result of a beat.
    a_end_bnd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tlast)
        else $error("grid end on a non-boundary or non-final result");

    a_gain_rb: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready && paddr == GAIN_ADDR
        |=> paddr != GAIN_ADDR || prdata == $past(pwdata))
        else $error("gain readback mismatch");

endmodule : js3d_port_assert

bind jacobi_stencil_3d_step_top js3d_port_assert u_js3d_port_assert (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
);

`default_nettype wire

### verif/js3d_checker.sv
// Scoreboard for the 3D Jacobi stencil step: watches both stream channels and the
// APB port, predicts every result beat and compares it. Depends on js3d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module js3d_checker #(
    parameter int MAX_X     = 64,
    parameter int MAX_Y     = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    input  wire                          s_tready,
    input  wire  [63:0]                  s_tdata,
    input  wire                          m_tvalid,
    input  wire                          m_tready,
    input  wire  [31:0]                  m_tdata,
    input  wire  [1:0]                   m_tuser,
    input  wire                          m_tlast,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire                          pready,
    input  wire  [js3d_pkg::PADDR_W-1:0] paddr,
    input  wire  [31:0]                  pwdata,
    output int                           fail_count,
    output int                           pending_count,
    output int                           result_count
);

    localparam int PTS = MAX_X * MAX_Y;

    typedef struct packed {
        logic [31:0] value;
        logic        boundary;
        logic        grid_end;
        logic        last;
    } point_result_t;

    point_result_t expected_points[$];

    logic [js3d_pkg::SXY_W-1:0] cfg_sx, cfg_sy;
    logic [js3d_pkg::SZ_W-1:0]  cfg_sz;
    logic [31:0]                cfg_gain;
    logic [31:0]                value_plane [2*PTS];
    logic [31:0]                source_plane [PTS];
    int unsigned                col, row, pln;

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        return v < js3d_pkg::SIZE_MIN ? js3d_pkg::SIZE_MIN : (v > hi ? hi : v);
    endfunction

    function automatic int unsigned cell_at(int unsigned x, int unsigned y);
        return (y * MAX_X + x) % PTS;
    endfunction

    function automatic logic signed [63:0] round_div6(logic signed [63:0] s);
        logic signed [63:0] q;
        q = (s + 3) / 6;
        // Truncating division: correct negative non-exact quotients down to floor.
        if ((s + 3) < 0 && ((s + 3) % 6) != 0) q = q - 1;
        return q;
    endfunction

    // Updated value of an interior point of plane pln-1.
    function automatic logic signed [63:0] jacobi_point(int unsigned half, int unsigned x,
            int unsigned y, logic signed [63:0] above, logic signed [63:0] below,
            logic signed [63:0] src);
        logic signed [63:0] sum, t1, t2, r;
        int unsigned b;
        b = half * PTS;
        sum = above + below
            + $signed(value_plane[b + cell_at(x + 1, y)])
            + $signed(value_plane[b + cell_at(x - 1, y)])
            + $signed(value_plane[b + cell_at(x, y + 1)])
            + $signed(value_plane[b + cell_at(x, y - 1)]);
        t1 = round_div6(sum);
        t2 = ($signed(cfg_gain) * src + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        r = t1 + t2;
        if (r > 64'sh7FFFFFFF) r = 64'sh7FFFFFFF;
        if (r < -64'sh80000000) r = -64'sh80000000;
        return r;
    endfunction

    task automatic predict_point(logic [31:0] oldv, logic [31:0] srcv);
        int unsigned sx, sy, sz, pt_idx, cur, prv;
        logic last_plane, last_point, bnd;
        logic signed [63:0] v;
        point_result_t pr;
        sx = clamp_size(cfg_sx, MAX_X);
        sy = clamp_size(cfg_sy, MAX_Y);
        sz = clamp_size(cfg_sz, js3d_pkg::MAX_Z);
        pt_idx = cell_at(col, row);
        cur = (pln & 1) * PTS + pt_idx;
        prv = ((pln & 1) ^ 1) * PTS + pt_idx;
        last_plane = pln >= sz - 1;
        last_point = col >= sx - 1 && row >= sy - 1;
        if (pln >= 1) begin
            bnd = pln == 1 || pln - 1 >= sz - 1 || col == 0 || row == 0
                || col >= sx - 1 || row >= sy - 1;
            v = $signed(value_plane[prv]);
            if (!bnd)
                v = jacobi_point((pln & 1) ^ 1, col, row, $signed(oldv),
                    $signed(value_plane[cur]), $signed(source_plane[pt_idx]));
            pr = '{v[31:0], bnd, 1'b0, !last_plane};
            expected_points.push_back(pr);
        end
        value_plane[cur] = oldv;
        source_plane[pt_idx] = srcv;
        if (last_plane) begin
            pr = '{oldv, 1'b1, last_point, 1'b1};
            expected_points.push_back(pr);
        end
        if (col + 1 >= sx) begin
            col = 0;
            if (row + 1 >= sy) begin
                row = 0;
                pln = (pln + 1 >= sz) ? 0 : pln + 1;
            end else begin
                row = row + 1;
            end
        end else begin
            col = col + 1;
        end
    endtask

    always @(posedge aclk) begin
        point_result_t want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            cfg_sx <= js3d_pkg::SIZE_X_RST;
            cfg_sy <= js3d_pkg::SIZE_Y_RST;
            cfg_sz <= js3d_pkg::SIZE_Z_RST;
            cfg_gain <= js3d_pkg::GAIN_RST;
            col = 0;
            row = 0;
            pln = 0;
            fail_count <= 0;
            result_count <= 0;
            expected_points.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (js3d_pkg::reg_idx_t'(paddr[3:2]))
                    js3d_pkg::REG_SIZE_X: cfg_sx <= pwdata[js3d_pkg::SXY_W-1:0];
                    js3d_pkg::REG_SIZE_Y: cfg_sy <= pwdata[js3d_pkg::SXY_W-1:0];
                    js3d_pkg::REG_SIZE_Z: cfg_sz <= pwdata[js3d_pkg::SZ_W-1:0];
                    js3d_pkg::REG_GAIN:   cfg_gain <= pwdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                result_count <= result_count + 1;
                if (expected_points.size() == 0) begin
                    $error("unexpected result beat: new_value %h", m_tdata);
                    errs++;
                end else begin
                    want = expected_points.pop_front();
                    if (m_tdata !== want.value) begin
                        $error("new_value: expected %h, got %h", want.value, m_tdata);
                        errs++;
                    end
                    if (m_tuser[0] !== want.boundary) begin
                        $error("is_boundary: expected %b, got %b", want.boundary, m_tuser[0]);
                        errs++;
                    end
                    if (m_tuser[1] !== want.grid_end) begin
                        $error("grid_end: expected %b, got %b", want.grid_end, m_tuser[1]);
                        errs++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %b, got %b", want.last, m_tlast);
                        errs++;
                    end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
            if (s_tvalid && s_tready) predict_point(s_tdata[31:0], s_tdata[63:32]);
        end
        pending_count <= expected_points.size();
    end

endmodule

`default_nettype wire

### verif/testbench.sv
// Top of the stencil step testbench: clock, reset, APB setup, stream stimulus with
// bursty sender and stalling receiver, verdict. Depends on js3d_pkg, js3d_checker, DUT.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [js3d_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending_count, result_count;
    int          beats_sent = 0;
    int          grids_done = 0;
    // Set by the stimulus to freeze the receiver for a long stretch.
    logic        hold_off = 1'b0;
    // Current value range mode for the random part.
    int          value_mode = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    jacobi_stencil_3d_step_top DUT (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .m_tuser, .m_tlast, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready
    );

    js3d_checker checker_i (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .m_tuser, .m_tlast, .psel, .penable, .pwrite, .pready, .paddr,
        .pwdata, .fail_count, .pending_count, .result_count
    );

    // The receiver stalls on its own pattern: phases of always-ready, of random
    // stalls and of heavy stalls, plus the long hold-off on request.
    initial begin
        int phase_len, style;
        forever begin
            phase_len = $urandom_range(10, 200);
            style = $urandom_range(0, 2);
            repeat (phase_len) begin
                @(negedge aclk);
                if (hold_off) m_tready <= 1'b0;
                else case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 3) != 0;
                    default: m_tready <= $urandom_range(0, 3) == 0;
                endcase
            end
        end
    end

    // One APB write: setup cycle, then access cycle; pready is always high.
    task automatic apb_write(js3d_pkg::reg_idx_t idx, logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFFFFFF;
            3: return $urandom;
            default: return value_mode == 0 ? $urandom : $signed($urandom_range(0, 8'hFF)) - 128;
        endcase
    endfunction

    // Offer one beat; valid stays high across back-to-back beats of a burst.
    task automatic send_point(logic [31:0] oldv, logic [31:0] srcv);
        s_tvalid <= 1'b1;
        s_tdata <= {srcv, oldv};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
        @(negedge aclk);
    endtask

    // Streams one whole grid with bursts and gaps, so every store entry read is
    // written first. Extreme values can be forced for the directed grid.
    task automatic send_grid(int sx, int sy, int sz, bit directed);
        int burst, k;
        logic [31:0] ov, sv;
        k = 0;
        burst = $urandom_range(1, 40);
        for (int i = 0; i < sx * sy * sz; i++) begin
            if (directed) begin
                ov = (k % 4 == 0) ? 32'h7FFFFFFF : (k % 4 == 1) ? 32'h80000000 : $urandom;
                sv = (k % 3 == 0) ? 32'h7FFFFFFF : (k % 3 == 1) ? 32'h80000000 : 32'h0;
            end else begin
                ov = pick_value();
                sv = pick_value();
            end
            send_point(ov, sv);
            k++;
            if (--burst == 0) begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 2) != 0) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(negedge aclk);
                end
            end
        end
        s_tvalid <= 1'b0;
        grids_done++;
    endtask

    // Waits for all results, then lets the pipeline drain before a register write.
    task automatic drain();
        while (pending_count != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic set_grid(int sx, int sy, int sz, logic [31:0] gain);
        apb_write(js3d_pkg::REG_SIZE_X, 32'(sx));
        apb_write(js3d_pkg::REG_SIZE_Y, 32'(sy));
        apb_write(js3d_pkg::REG_SIZE_Z, 32'(sz));
        apb_write(js3d_pkg::REG_GAIN, gain);
    endtask

    initial begin
        int sx, sy, sz;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: smallest grid, largest gain, extreme values; two results per
        // beat on the last plane and the grid end flag.
        set_grid(3, 3, 3, 32'h7FFFFFFF);
        send_grid(3, 3, 3, 1'b1);
        drain();
        // Sizes below range saturate up; a write at the unaligned address 0xF
        // decodes to the gain register.
        set_grid(1, 0, 2, 32'h80000000);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 4'hF; pwdata <= 32'hFFFFFFFF;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        send_grid(3, 3, 3, 1'b1);
        drain();

        // Long receiver hold-off while a grid streams, to fill the result queue.
        set_grid(4, 3, 4, 32'd65536);
        fork
            send_grid(4, 3, 4, 1'b0);
            begin
                hold_off <= 1'b1;
                repeat (150) @(negedge aclk);
                hold_off <= 1'b0;
            end
        join
        drain();

        // An oversized width register saturates to the widest row of 64 points.
        set_grid(127, 3, 3, 32'h0000_8000);
        send_grid(64, 3, 3, 1'b0);
        drain();

        // Random small grids with assorted gains until the beat budget is spent.
        while (beats_sent < 800) begin
            sx = $urandom_range(3, 8);
            sy = $urandom_range(3, 6);
            sz = $urandom_range(3, 6);
            value_mode = $urandom_range(0, 1);
            set_grid(sx, sy, sz,
                $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h30000));
            send_grid(sx, sy, sz, 1'b0);
            drain();
        end

        $display("Covered %0d input beats in %0d grids, %0d result beats checked.",
            beats_sent, grids_done, result_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
design/js3d_pkg.sv
design/jacobi_stencil_3d_step_top.sv
design/js3d_checker.sv
verif/js3d_checker.sv
verif/testbench.sv
